// File: sv/mark_sweep_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mark-and-sweep slot allocator
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MARK_SWEEP_SLOT_ALLOCATOR_MACROS_SVH
`define MARK_SWEEP_SLOT_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MSSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MSSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mssa_pkg.sv
// ----------------------------------------------------------------------------
// mssa_pkg
// Types, constants and word helpers shared by the slot allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mssa_pkg;

    // Pool geometry: the bitmaps are held as words of WORD_W slots
    localparam int POOL_SLOTS = 1024;
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = POOL_SLOTS / WORD_W;
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int BIT_AW     = $clog2(WORD_W);
    localparam int BYTES_W    = WORD_W / 8;

    // Field widths
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OP_SWEEP = 3'd3;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot_index;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_W-1:0]  granted_slot;
        logic               success;
        logic               already_marked;
        logic [COUNT_W-1:0] slots_in_use;
    } t_out_beat;

    // Request from the control FSM to the bitmap store
    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_word;
        logic               wr_use;
        logic               wr_mrk;
        logic [WORD_AW-1:0] wr_word;
        logic [WORD_W-1:0]  use_wd;
        logic [WORD_W-1:0]  mrk_wd;
        logic               clr_marks;
    } t_map_req;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] pos;
    } t_find;

    // Lowest clear bit of a word: per byte first, then the lowest byte with one
    function automatic t_find f_first_zero(input logic [WORD_W-1:0] w);
        t_find r;
        r = '0;
        for (int b = BYTES_W - 1; b >= 0; b--) begin
            if (!(&w[b*8 +: 8])) begin
                r.found = 1'b1;
                r.pos[BIT_AW-1:3] = (BIT_AW-3)'(b);
                for (int k = 7; k >= 0; k--) begin
                    if (!w[b*8 + k]) begin
                        r.pos[2:0] = 3'(k);
                    end
                end
            end
        end
        return r;
    endfunction

    // Number of set bits in a word, summed byte by byte
    function automatic logic [BIT_AW:0] f_popcount(input logic [WORD_W-1:0] w);
        logic [BIT_AW:0] total;
        logic [3:0]      part;
        total = '0;
        for (int b = 0; b < BYTES_W; b++) begin
            part = '0;
            for (int k = 0; k < 8; k++) begin
                part = part + 4'(w[b*8 + k]);
            end
            total = total + (BIT_AW+1)'(part);
        end
        return total;
    endfunction

endpackage

`default_nettype wire

// File: sv/mssa_bitmap.sv
// ----------------------------------------------------------------------------
// mssa_bitmap
// Used and mark bitmaps as two word-wide synchronous memories with registered
// reads. A per-word valid bit stands in for the reset clear: a word
// never written since reset (or, in the mark map, since a mark clear) reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mssa_bitmap
    import mssa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_map_req          i_req,
    output logic [WORD_W-1:0]      o_use_word,
    output logic [WORD_W-1:0]      o_mrk_word
);

    logic [WORD_W-1:0]    r_use_mem [NUM_WORDS];
    logic [WORD_W-1:0]    r_mrk_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_use_vld;
    logic [NUM_WORDS-1:0] r_mrk_vld;
    logic [WORD_W-1:0]    r_use_q;
    logic [WORD_W-1:0]    r_mrk_q;
    logic                 r_use_qv;
    logic                 r_mrk_qv;

    // Write and read the memory arrays
    always_ff @(posedge i_clk) begin
        if (i_req.wr_use) begin
            r_use_mem[i_req.wr_word] <= i_req.use_wd;
        end
        if (i_req.wr_mrk) begin
            r_mrk_mem[i_req.wr_word] <= i_req.mrk_wd;
        end
        if (i_req.rd_en) begin
            r_use_q <= r_use_mem[i_req.rd_word];
            r_mrk_q <= r_mrk_mem[i_req.rd_word];
        end
    end

    // Track written words; drop all mark words at once on a clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_vld <= '0;
            r_mrk_vld <= '0;
            r_use_qv  <= 1'b0;
            r_mrk_qv  <= 1'b0;
        end else begin
            if (i_req.wr_use) begin
                r_use_vld[i_req.wr_word] <= 1'b1;
            end
            if (i_req.clr_marks) begin
                r_mrk_vld <= '0;
            end else if (i_req.wr_mrk) begin
                r_mrk_vld[i_req.wr_word] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_use_qv <= r_use_vld[i_req.rd_word];
                r_mrk_qv <= r_mrk_vld[i_req.rd_word];
            end
        end
    end

    // Mask words that hold no written data
    assign o_use_word = r_use_qv ? r_use_q : '0;
    assign o_mrk_word = r_mrk_qv ? r_mrk_q : '0;

endmodule

`default_nettype wire

// File: sv/mark_sweep_slot_allocator.sv
// ----------------------------------------------------------------------------
// mark_sweep_slot_allocator
// Bitmap slot allocator for a 1024-slot pool with mark-and-sweep support.
//
// Input channel i_in_valid / o_in_stall / i_in_beat carries one operation a
// beat: allocate, mark, clear marks, sweep or free. Output channel
// o_out_valid / i_out_stall / o_out_beat returns exactly one result beat per
// input beat, in order. A beat moves when valid is high and stall is low.
// The bitmaps sit in two 16 x 64-bit memories read one word a cycle.
// Steps from input beat to result valid:
//   clear marks, undefined op, out-of-range slot: result registered on acceptance
//   mark, free: one word read, then modify and write back
//   allocate: a word scan that stops at the first free slot
//   sweep: a read-modify-write of all 16 words plus a count update
// One operation is in flight at a time; o_in_stall stays high until its
// result is registered. A result waiting under i_out_stall holds the next
// beat off. Reset clears both bitmaps at once through per-word valid bits,
// zeroes the slot count and empties the output; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mark_sweep_slot_allocator
    import mssa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

`include "mark_sweep_slot_allocator_macros.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_SINGLE = 3'd4;

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

    logic [2:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [WORD_AW:0]    r_rd_word, n_rd_word;
    logic                r_chk_vld, n_chk_vld;
    logic [WORD_AW-1:0]  r_chk_word, n_chk_word;
    logic [BIT_AW:0]     r_freed, n_freed;
    logic                r_fvld, n_fvld;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_out_vld;
    t_out_beat           r_out, n_out;
    logic                out_load;
    logic                in_acc, out_acc;
    t_map_req            map_req;
    logic [WORD_W-1:0]   use_word, mrk_word;
    t_find               find;
    logic [WORD_W-1:0]   idx_onehot;
    logic [BIT_AW-1:0]   idx_bit;
    logic [WORD_AW-1:0]  idx_word;
    logic                in_range;

    mssa_bitmap u_bitmap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (map_req),
        .o_use_word (use_word),
        .o_mrk_word (mrk_word)
    );

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_vld && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_vld && !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    // Word helpers
    assign find       = f_first_zero(use_word);
    assign idx_bit    = r_idx[BIT_AW-1:0];
    assign idx_word   = r_idx[SLOT_W-1:BIT_AW];
    assign idx_onehot = WORD_W'(1) << idx_bit;
    assign in_range   = 32'(i_in_beat.slot_index) < POOL_SLOTS;

    // Sequence each operation over the bitmap words
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_idx      = r_idx;
        n_rd_word  = r_rd_word;
        n_chk_vld  = 1'b0;
        n_chk_word = r_chk_word;
        n_freed    = r_freed;
        n_fvld     = 1'b0;
        n_count    = r_count;
        map_req    = '0;
        out_load   = 1'b0;
        n_out      = '0;
        n_out.granted_slot = r_idx;

        unique case (r_state)
            S_IDLE: begin
                n_out.granted_slot = i_in_beat.slot_index;
                if (in_acc) begin
                    n_op  = i_in_beat.op;
                    n_idx = i_in_beat.slot_index;
                    case (i_in_beat.op) inside
                        OP_ALLOC, OP_SWEEP: begin
                            map_req.rd_en   = 1'b1;
                            map_req.rd_word = '0;
                            n_rd_word       = (WORD_AW+1)'(1);
                            n_chk_vld       = 1'b1;
                            n_chk_word      = '0;
                            n_state = (i_in_beat.op == OP_ALLOC) ? S_ALLOC : S_SWEEP;
                        end
                        OP_MARK, OP_FREE: begin
                            if (in_range) begin
                                map_req.rd_en   = 1'b1;
                                map_req.rd_word = i_in_beat.slot_index[SLOT_W-1:BIT_AW];
                                n_chk_vld       = 1'b1;
                                n_state         = S_SINGLE;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            map_req.clr_marks = 1'b1;
                            out_load          = 1'b1;
                            n_out.success     = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // Issue the next word read while checking the previous one
                if (r_rd_word < (WORD_AW+1)'(NUM_WORDS)) begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_word = r_rd_word[WORD_AW-1:0];
                    n_rd_word       = r_rd_word + 1'b1;
                    n_chk_vld       = 1'b1;
                    n_chk_word      = r_rd_word[WORD_AW-1:0];
                end
                if (r_chk_vld && find.found) begin
                    map_req.wr_use     = 1'b1;
                    map_req.wr_word    = r_chk_word;
                    map_req.use_wd     = use_word | (WORD_W'(1) << find.pos);
                    n_count            = r_count + 1'b1;
                    out_load           = 1'b1;
                    n_out.success      = 1'b1;
                    n_out.granted_slot = SLOT_W'({r_chk_word, find.pos});
                    n_chk_vld          = 1'b0;
                    n_state            = S_IDLE;
                end else if (r_chk_vld && r_chk_word == LAST_WORD) begin
                    out_load  = 1'b1;
                    n_chk_vld = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            S_SWEEP: begin
                if (r_rd_word < (WORD_AW+1)'(NUM_WORDS)) begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_word = r_rd_word[WORD_AW-1:0];
                    n_rd_word       = r_rd_word + 1'b1;
                    n_chk_vld       = 1'b1;
                    n_chk_word      = r_rd_word[WORD_AW-1:0];
                end
                // Apply the previous word's freed count
                if (r_fvld) begin
                    n_count = r_count - COUNT_W'(r_freed);
                end
                // Keep only marked slots in use
                if (r_chk_vld) begin
                    map_req.wr_use  = 1'b1;
                    map_req.wr_word = r_chk_word;
                    map_req.use_wd  = use_word & mrk_word;
                    n_freed         = f_popcount(use_word & ~mrk_word);
                    n_fvld          = 1'b1;
                    if (r_chk_word == LAST_WORD) begin
                        n_state = S_DRAIN;
                    end
                end
            end

            S_DRAIN: begin
                n_count       = r_count - COUNT_W'(r_freed);
                out_load      = 1'b1;
                n_out.success = 1'b1;
                n_state       = S_IDLE;
            end

            S_SINGLE: begin
                map_req.wr_word = idx_word;
                out_load        = 1'b1;
                n_state         = S_IDLE;
                if (r_op == OP_MARK) begin
                    map_req.wr_mrk       = 1'b1;
                    map_req.mrk_wd       = mrk_word | idx_onehot;
                    n_out.success        = 1'b1;
                    n_out.already_marked = mrk_word[idx_bit];
                end else if (use_word[idx_bit]) begin
                    map_req.wr_use = 1'b1;
                    map_req.use_wd = use_word & ~idx_onehot;
                    n_count        = r_count - 1'b1;
                    n_out.success  = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.slots_in_use = n_count;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_word <= '0;
            r_chk_vld <= 1'b0;
            r_fvld    <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_word <= n_rd_word;
            r_chk_vld <= n_chk_vld;
            r_fvld    <= n_fvld;
            r_count   <= n_count;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_chk_word <= n_chk_word;
        r_freed    <= n_freed;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    `MSSA_ASSERT_SAME(a_count_bound, 1'b1, r_count <= COUNT_W'(POOL_SLOTS), "slot count beyond pool")
    `MSSA_ASSERT_NEXT(a_accept_busy, in_acc, r_out_vld || r_state != S_IDLE, "beat accepted but no work")
    `MSSA_ASSERT_SAME(a_alloc_fail_full, out_load && r_state == S_ALLOC && !n_out.success, r_count == COUNT_W'(POOL_SLOTS), "allocate failed with free slots")
    `MSSA_ASSERT_SAME(a_out_free, out_load, !r_out_vld || out_acc, "result overwrites pending beat")

endmodule

`default_nettype wire

// File: tb/sv/mark_sweep_slot_allocator_checker.sv
// ----------------------------------------------------------------------------
// mark_sweep_slot_allocator_checker
// Watches both channels of the slot allocator. Each accepted input beat is
// run through a local model of the used map, mark map and slot count. The
// predicted result is queued, and every accepted result beat is compared
// field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module mark_sweep_slot_allocator_checker
    import mssa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_beat  i_in_beat,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_beat i_out_beat,
    output int             o_fail_count,
    output int             o_pending
);

    // Local copy of the allocator state
    logic [POOL_SLOTS-1:0] used_bits;
    logic [POOL_SLOTS-1:0] marked_bits;
    int unsigned           used_total;

    t_out_beat             pending_results[$];
    int                    result_no;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_no    = 0;
        used_bits    = '0;
        marked_bits  = '0;
        used_total   = 0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s is %0d, expected %0d", result_no, what, got, want);
        o_fail_count++;
    endtask

    // Apply one operation to the local state and work out its result beat
    task automatic apply_slot_op(input t_in_beat b, output t_out_beat r);
        logic found;
        int   idx;
        found            = 1'b0;
        idx              = int'(b.slot_index);
        r.granted_slot   = b.slot_index;
        r.success        = 1'b0;
        r.already_marked = 1'b0;
        case (b.op)
            OP_ALLOC: begin
                for (int i = 0; i < POOL_SLOTS; i++) begin
                    if (!found && !used_bits[i]) begin
                        found          = 1'b1;
                        used_bits[i]   = 1'b1;
                        used_total++;
                        r.granted_slot = SLOT_W'(i);
                        r.success      = 1'b1;
                    end
                end
            end
            OP_MARK: begin
                if (idx < POOL_SLOTS) begin
                    r.already_marked = marked_bits[idx];
                    marked_bits[idx] = 1'b1;
                    r.success        = 1'b1;
                end
            end
            OP_CLEAR: begin
                marked_bits = '0;
                r.success   = 1'b1;
            end
            OP_SWEEP: begin
                for (int i = 0; i < POOL_SLOTS; i++) begin
                    if (used_bits[i] && !marked_bits[i]) begin
                        used_bits[i] = 1'b0;
                        if (used_total > 0) used_total--;
                    end
                end
                r.success = 1'b1;
            end
            OP_FREE: begin
                if (idx < POOL_SLOTS && used_bits[idx]) begin
                    used_bits[idx] = 1'b0;
                    if (used_total > 0) used_total--;
                    r.success = 1'b1;
                end
            end
            default: begin
                // undefined codes leave the state alone
            end
        endcase
        r.slots_in_use = COUNT_W'(used_total);
    endtask

    // Compare results first, then queue the prediction for a new input beat
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat predicted;
        if (!i_rst_n) begin
            used_bits   = '0;
            marked_bits = '0;
            used_total  = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                result_no++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, granted_slot",
                                    int'(i_out_beat.granted_slot), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_beat.granted_slot !== want.granted_slot)
                        report_mismatch("granted_slot", int'(i_out_beat.granted_slot),
                                        int'(want.granted_slot));
                    if (i_out_beat.success !== want.success)
                        report_mismatch("success", int'(i_out_beat.success),
                                        int'(want.success));
                    if (i_out_beat.already_marked !== want.already_marked)
                        report_mismatch("already_marked", int'(i_out_beat.already_marked),
                                        int'(want.already_marked));
                    if (i_out_beat.slots_in_use !== want.slots_in_use)
                        report_mismatch("slots_in_use", int'(i_out_beat.slots_in_use),
                                        int'(want.slots_in_use));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_slot_op(i_in_beat, predicted);
                pending_results.push_back(predicted);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_mark_sweep_slot_allocator.sv
// ----------------------------------------------------------------------------
// tb_mark_sweep_slot_allocator
// Drives operation beats into the slot allocator and back-pressures its
// results with random gaps. A directed opening covers the corner cases, a
// fill phase loads the low end of the pool, and a random phase mixes allocate
// bursts, mark and sweep rounds, frees and noise. Checking is done by the
// checker module beside the block; this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mark_sweep_slot_allocator;
    import mssa_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_ITEMS   = 240;
    localparam int FILL_ITEMS     = 128;
    localparam int MAX_IDLE       = 10;

    // Undefined operation codes
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_beat;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_beat;

    int        fail_count;
    int        pending;
    int        items_sent;
    int        quiet_cycles;
    logic      idle_on;

    mark_sweep_slot_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    mark_sweep_slot_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_beat    (i_in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_beat   (o_out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock, period 4
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Known values from the start
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_beat   = '0;
        i_out_stall = 1'b0;
        idle_on     = 1'b1;
        items_sent  = 0;
    end

    // Watchdog: end the run after too long without any beat moving
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: hold stall for a random number of cycles per beat
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // Present one beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid           <= 1'b1;
        i_in_beat.op         <= op;
        i_in_beat.slot_index <= idx;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly low slots, where allocations land, sometimes anywhere
    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 3) != 0) return SLOT_W'($urandom_range(0, 63));
        return SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
    endfunction

    // Stimulus and verdict
    initial begin
        int n;
        int target;
        logic pressed;
        pressed = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty pool, repeated marks, sweep, frees, bad codes
        send_beat(OP_SWEEP, 10'd1023);
        send_beat(OP_FREE,  10'd0);
        send_beat(OP_MARK,  10'd1023);
        send_beat(OP_MARK,  10'd1023);
        send_beat(OP_CLEAR, 10'd0);
        send_beat(OP_ALLOC, 10'd1023);
        send_beat(OP_ALLOC, 10'd0);
        send_beat(OP_ALLOC, 10'd512);
        send_beat(OP_MARK,  10'd1);
        send_beat(OP_SWEEP, 10'd0);
        send_beat(OP_FREE,  10'd1);
        send_beat(OP_FREE,  10'd1);
        send_beat(OP_RSVD5, 10'd1023);
        send_beat(OP_RSVD6, 10'd0);
        send_beat(OP_RSVD7, 10'd682);
        send_beat(OP_RSVD7, 10'd341);
        send_beat(OP_ALLOC, 10'd341);
        send_beat(OP_MARK,  10'd0);
        send_beat(OP_CLEAR, 10'd682);
        send_beat(OP_SWEEP, 10'd1023);
        wait_drained();

        // Fill the low end of the pool across two bitmap words
        for (int i = 0; i < FILL_ITEMS; i++) begin
            if (i % 32 == 0) idle_on = $urandom_range(0, 1);
            send_beat(OP_ALLOC, SLOT_W'($urandom_range(0, POOL_SLOTS - 1)));
        end
        idle_on = 1'b1;
        n = $urandom_range(8, 24);
        repeat (n) send_beat(OP_MARK, SLOT_W'($urandom_range(0, POOL_SLOTS - 1)));
        send_beat(OP_FREE, 10'd1023);
        send_beat(OP_SWEEP, pick_slot());
        send_beat(OP_CLEAR, pick_slot());

        // Random phase: mostly well-formed rounds, some noise
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (!pressed && items_sent > target - RANDOM_ITEMS / 2) begin
                pressed = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 16);
                    repeat (n) send_beat(OP_ALLOC, pick_slot());
                end
                3, 4: begin
                    if ($urandom_range(0, 1)) send_beat(OP_CLEAR, pick_slot());
                    n = $urandom_range(0, 12);
                    repeat (n) send_beat(OP_MARK, pick_slot());
                    send_beat(OP_SWEEP, pick_slot());
                end
                5, 6: begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_beat(OP_FREE, pick_slot());
                end
                7: begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_beat(OP_MARK, pick_slot());
                end
                8: begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_beat(OP_W'($urandom_range(0, 7)),
                                         SLOT_W'($urandom_range(0, POOL_SLOTS - 1)));
                end
                default: begin
                    if ($urandom_range(0, 1)) send_beat(OP_SWEEP, pick_slot());
                    else send_beat(OP_CLEAR, pick_slot());
                end
            endcase
        end

        // Drain, let any stray result show up, then give the verdict
        idle_on = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
